// File: hw/rtl/lkvc_pkg.sv
// Package for the LRU key-value cache: shared widths, reset values and
// the control struct broadcast from the top level to the cell row.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int DEF_KEY_BITS = 16;
    localparam int VAL_W        = 32;
    localparam int CAP_W        = 5;
    // cell positions and count, wide enough for the largest row (64)
    localparam int POS_W        = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic             miss_put;
        logic [POS_W-1:0] stop_pos;
    } lkvc_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/lru_key_value_cache_unit.sv
// Usage notes
// Fully associative key-value cache with least-recently-used replacement.
// Input channel s_*: tuser is cmd (0 get, 1 put); tdata holds key then value.
// Output channel m_*: tuser holds hit then evicted; tdata holds read_value
// then evicted_key. One result transfer per input transfer, in order.
// Entries sit in a row of cells ordered by recency, cell 0 most recent.
// A request compares all cells at once; on a hit or a put a shift wave runs
// from cell 0 to the stop cell (hit entry, oldest entry or first free cell)
// and the request entry lands in cell 0, all at the accepting edge.
// The result is registered at the accepting edge, valid in the next cycle.
// Throughput: one request per cycle while m_tready is high.
// A stalled result holds in the output register; s_tready stays high only
// while that register is empty or being drained.
// Reset empties the cache and sets capacity to 16. cfg_we writes capacity
// (0 acts as 1, above CAPACITY acts as CAPACITY); write only while idle.
// Depends on lkvc_pkg and lkvc_cell.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache_unit
    import lkvc_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int KEY_BITS = DEF_KEY_BITS,
    localparam int IN_W    = ((KEY_BITS + VAL_W + 7) / 8) * 8,
    localparam int OUT_W   = ((VAL_W + KEY_BITS + 7) / 8) * 8
)
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cfg_we,
    input  wire  [CAP_W-1:0] cfg_wdata,
    input  wire              s_tvalid,
    output logic             s_tready,
    input  wire  [IN_W-1:0]  s_tdata,   // key, value
    input  wire              s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire              m_tready,
    output logic [OUT_W-1:0] m_tdata,   // read_value, evicted_key
    output logic [1:0]       m_tuser    // hit, evicted
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int W  = (CW > CAP_W) ? CW : CAP_W;

    logic [CAP_W-1:0]    cap_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                out_valid_reg;
    logic                hit_reg;
    logic [VAL_W-1:0]    rd_reg;
    logic                ev_reg;
    logic [KEY_BITS-1:0] evk_reg;

    logic                accept;
    logic                cmd;
    logic [KEY_BITS-1:0] req_key;
    logic [VAL_W-1:0]    req_value;
    logic [CAP_W-1:0]    cap_eff;
    logic                evict;
    logic                hit;
    logic                miss_put;
    logic [VAL_W-1:0]    hit_value;
    logic [KEY_BITS-1:0] drop_key;
    lkvc_ctrl_t          ctrl;

    logic                carry [CAPACITY+1];
    logic                cvalid[CAPACITY];
    logic [KEY_BITS-1:0] ckey  [CAPACITY];
    logic [VAL_W-1:0]    cvalue[CAPACITY];
    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] drop_vec;
    logic [VAL_W-1:0]    ins_value0;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cmd       = s_tuser;
    assign req_key   = s_tdata[KEY_BITS-1:0];
    assign req_value = s_tdata[KEY_BITS +: VAL_W];

    assign cap_eff  = (cap_reg == '0) ? CAP_W'(1) : cap_reg;
    assign evict    = (count_reg == CW'(CAPACITY)) || (W'(count_reg) >= W'(cap_eff));
    assign hit      = |match_vec;
    assign miss_put = accept && !hit && (cmd == CMD_PUT);

    assign ctrl.miss_put = miss_put;
    assign ctrl.stop_pos = evict ? POS_W'(count_reg - CW'(1)) : POS_W'(count_reg);

    // shift wave starts at cell 0 for any hit or any put
    assign carry[0] = accept && (hit || (cmd == CMD_PUT));

    always_comb
    begin
        hit_value = '0;
        drop_key  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_vec[i])
            begin
                hit_value = hit_value | cvalue[i];
            end
            if (drop_vec[i])
            begin
                drop_key = drop_key | ckey[i];
            end
        end
    end

    assign ins_value0 = (cmd == CMD_PUT) ? req_value : hit_value;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        lkvc_cell #(
            .KEY_BITS (KEY_BITS),
            .IDX      (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .search_key (req_key),
            .carry_in   (carry[g]),
            .ins_valid  ((g == 0) ? 1'b1 : cvalid[(g == 0) ? 0 : g - 1]),
            .ins_key    ((g == 0) ? req_key : ckey[(g == 0) ? 0 : g - 1]),
            .ins_value  ((g == 0) ? ins_value0 : cvalue[(g == 0) ? 0 : g - 1]),
            .carry_out  (carry[g+1]),
            .valid      (cvalid[g]),
            .key        (ckey[g]),
            .value      (cvalue[g]),
            .match      (match_vec[g]),
            .drop       (drop_vec[g])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (miss_put && !evict)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg <= hit;
            rd_reg  <= (hit && (cmd == CMD_GET)) ? hit_value : '0;
            ev_reg  <= miss_put && evict;
            evk_reg <= (miss_put && evict) ? drop_key : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {ev_reg, hit_reg};

    always_comb
    begin
        m_tdata = '0;
        m_tdata[VAL_W-1:0] = rd_reg;
        m_tdata[VAL_W +: KEY_BITS] = evk_reg;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond row length");

    a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("key held in more than one cell");

    a_evict_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (miss_put && evict) |=> $stable(count_reg))
        else $error("count moved on an eviction");

    a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> !m_tuser[0])
        else $error("eviction reported on a hit");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/lkvc_cell.sv
// One cache cell: holds one entry, compares it against the search key and
// takes its neighbour's entry when the shift wave reaches it.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lkvc_cell
    import lkvc_pkg::*;
#(
    parameter int KEY_BITS = DEF_KEY_BITS,
    parameter int IDX      = 0
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  lkvc_ctrl_t          ctrl,
    input  wire  [KEY_BITS-1:0] search_key,
    input  wire                 carry_in,
    input  wire                 ins_valid,
    input  wire  [KEY_BITS-1:0] ins_key,
    input  wire  [VAL_W-1:0]    ins_value,
    output logic                carry_out,
    output logic                valid,
    output logic [KEY_BITS-1:0] key,
    output logic [VAL_W-1:0]    value,
    output logic                match,
    output logic                drop
);

    logic                valid_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [VAL_W-1:0]    value_reg;
    logic                at_stop;
    logic                stop;

    assign at_stop   = ctrl.miss_put && (ctrl.stop_pos == POS_W'(IDX));
    assign match     = valid_reg && (key_reg == search_key);
    assign stop      = match || at_stop;
    assign carry_out = carry_in && !stop;
    // evicting: the oldest live entry is the stop cell
    assign drop      = at_stop && valid_reg;

    assign valid = valid_reg;
    assign key   = key_reg;
    assign value = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (carry_in)
        begin
            valid_reg <= ins_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (carry_in)
        begin
            key_reg   <= ins_key;
            value_reg <= ins_value;
        end
    end

endmodule

`default_nettype wire

// File: tb/lru_cache_checker.sv
// Checker for the LRU key-value cache: watches the config port and both
// stream channels, keeps its own copy of the cache and compares every result.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lru_cache_checker
    import lkvc_pkg::*;
#(
    parameter int IN_W  = 48,
    parameter int OUT_W = 48
)
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cfg_we,
    input  wire  [CAP_W-1:0] cfg_wdata,
    input  wire              s_tvalid,
    input  wire              s_tready,
    input  wire  [IN_W-1:0]  s_tdata,   // key, value
    input  wire              s_tuser,   // cmd
    input  wire              m_tvalid,
    input  wire              m_tready,
    input  wire  [OUT_W-1:0] m_tdata,   // read_value, evicted_key
    input  wire  [1:0]       m_tuser,   // hit, evicted
    output int               fail_count,
    output int               outstanding
);

    localparam int KEY_W = DEF_KEY_BITS;
    localparam int SLOTS = DEF_CAPACITY;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } cache_resp_t;

    logic             slot_valid [SLOTS];
    logic [KEY_W-1:0] slot_key   [SLOTS];
    logic [VAL_W-1:0] slot_val   [SLOTS];
    int unsigned      slot_age   [SLOTS];
    int unsigned      n_entries;
    logic [CAP_W-1:0] capacity;

    cache_resp_t pending_resp [$];

    function automatic int unsigned capacity_limit();
        if (capacity == 0)
            return 1;
        if (capacity > SLOTS)
            return SLOTS;
        return 32'(capacity);
    endfunction

    // age 0 is most recent; valid ages are always 0 .. n_entries-1
    function automatic cache_resp_t lookup_and_update(input logic cmd,
                                                      input logic [KEY_W-1:0] k,
                                                      input logic [VAL_W-1:0] v);
        cache_resp_t r;
        int          i;
        int          found;
        int          target;
        int unsigned old_age;
        r = '0;
        found = -1;
        target = -1;
        for (i = 0; i < SLOTS; i++)
            if (found < 0 && slot_valid[i] && slot_key[i] == k)
                found = i;
        if (found >= 0)
        begin
            r.hit = 1'b1;
            if (cmd == CMD_GET)
                r.read_value = slot_val[found];
            else
                slot_val[found] = v;
            old_age = slot_age[found];
            for (i = 0; i < SLOTS; i++)
                if (slot_valid[i] && slot_age[i] < old_age)
                    slot_age[i]++;
            slot_age[found] = 0;
        end
        else if (cmd == CMD_PUT)
        begin
            if (n_entries >= capacity_limit() && n_entries > 0)
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (target < 0 && slot_valid[i] && slot_age[i] == n_entries - 1)
                    begin
                        r.evicted     = 1'b1;
                        r.evicted_key = slot_key[i];
                        slot_valid[i] = 1'b0;
                        slot_age[i]   = 0;
                        n_entries--;
                        target = i;
                    end
                end
            end
            if (target < 0)
                for (i = 0; i < SLOTS; i++)
                    if (target < 0 && !slot_valid[i])
                        target = i;
            if (target >= 0)
            begin
                for (i = 0; i < SLOTS; i++)
                    if (slot_valid[i])
                        slot_age[i]++;
                slot_valid[target] = 1'b1;
                slot_key[target]   = k;
                slot_val[target]   = v;
                slot_age[target]   = 0;
                n_entries++;
            end
        end
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cache_resp_t want;
        cache_resp_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_key[i]   = '0;
                slot_val[i]   = '0;
                slot_age[i]   = 0;
            end
            n_entries  = 0;
            capacity   = CAP_RESET;
            fail_count = 0;
            pending_resp.delete();
        end
        else
        begin
            if (cfg_we)
                capacity = cfg_wdata;
            if (m_tvalid && m_tready)
            begin
                got.hit         = m_tuser[0];
                got.evicted     = m_tuser[1];
                got.read_value  = m_tdata[VAL_W-1:0];
                got.evicted_key = m_tdata[VAL_W +: KEY_W];
                if (pending_resp.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, actual %h",
                             $time, got);
                    fail_count++;
                end
                else
                begin
                    want = pending_resp.pop_front();
                    compare_field("hit", 32'(want.hit), 32'(got.hit));
                    compare_field("read_value", want.read_value, got.read_value);
                    compare_field("evicted", 32'(want.evicted), 32'(got.evicted));
                    compare_field("evicted_key", 32'(want.evicted_key),
                                  32'(got.evicted_key));
                end
            end
            if (s_tvalid && s_tready)
                pending_resp.push_back(lookup_and_update(s_tuser, s_tdata[KEY_W-1:0],
                                                         s_tdata[KEY_W +: VAL_W]));
        end
        outstanding = pending_resp.size();
    end

endmodule

// File: tb/tb_lru_key_value_cache_unit.sv
// Top of the LRU key-value cache testbench: clock, reset, directed and
// random get/put traffic, capacity changes and the verdict.
// Depends on lkvc_pkg, lru_key_value_cache_unit and lru_cache_checker.
`timescale 1ns / 1ps

module tb_lru_key_value_cache_unit;
    import lkvc_pkg::*;

    localparam int KEY_W       = DEF_KEY_BITS;
    localparam int IN_W        = ((KEY_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_W       = ((VAL_W + KEY_W + 7) / 8) * 8;
    localparam int STALL_LIMIT = 2000;
    localparam int POOL_MAX    = 24;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 48;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CAP_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata   = '0;   // key, value
    logic              s_tuser   = CMD_GET;   // cmd
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;   // read_value, evicted_key
    logic [1:0]        m_tuser;   // hit, evicted

    int tx_idle_pct = 37;
    int rx_idle_pct = 52;
    int fail_count;
    int outstanding;
    int stall_cycles = 0;

    logic [KEY_W-1:0] key_pool [POOL_MAX];
    logic [CAP_W-1:0] phase_caps [PHASES] = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd17,
                                              5'd8, 5'd0, 5'd16, 5'd5};

    always #1 clk = ~clk;

    lru_key_value_cache_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    lru_cache_checker #(
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_req(input logic cmd, input logic [KEY_W-1:0] k,
                            input logic [VAL_W-1:0] v);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {v, k};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // hold the sender off until every result is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] c);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int               ph;
        int               n;
        int               pool_n;
        logic [KEY_W-1:0] k;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, extremes of key and value, update in place
        send_req(CMD_GET, 16'h0000, 32'h0000_0000);
        send_req(CMD_PUT, 16'h0000, 32'h8000_0000);
        send_req(CMD_PUT, 16'hFFFF, 32'h7FFF_FFFF);
        send_req(CMD_GET, 16'h0000, 32'hFFFF_FFFF);
        send_req(CMD_GET, 16'hFFFF, 32'h0000_0000);
        send_req(CMD_PUT, 16'h0000, 32'hFFFF_FFFF);
        send_req(CMD_GET, 16'h0000, 32'h0000_0000);
        send_req(CMD_GET, 16'h1234, 32'h5555_AAAA);

        // small capacity: eviction of the least recent entry
        set_capacity(5'd2);
        send_req(CMD_PUT, 16'h0005, 32'h0000_0005);
        send_req(CMD_PUT, 16'h0006, 32'h0000_0006);
        send_req(CMD_GET, 16'hFFFF, 32'h0000_0000);
        send_req(CMD_GET, 16'h0005, 32'h0000_0000);

        // zero acts as one; count stays above it, one eviction per new key
        set_capacity(5'd0);
        send_req(CMD_PUT, 16'h0007, 32'h0000_0007);
        send_req(CMD_PUT, 16'h0008, 32'hAAAA_5555);
        send_req(CMD_GET, 16'h0007, 32'h0000_0000);
        send_req(CMD_PUT, 16'h0009, 32'h1234_5678);
        send_req(CMD_GET, 16'h0008, 32'h0000_0000);

        for (ph = 0; ph < PHASES; ph++)
        begin
            tx_idle_pct = (ph < 3) ? 37 : (ph < 6) ? 52 : 0;
            rx_idle_pct = (ph < 3) ? 52 : (ph < 6) ? 37 : 0;
            set_capacity((ph == PHASES - 1) ? CAP_W'($urandom_range(2, 15))
                                            : phase_caps[ph]);
            pool_n = $urandom_range(2, POOL_MAX);
            for (n = 0; n < POOL_MAX; n++)
                key_pool[n] = KEY_W'($urandom_range(0, 16'hFFFF));
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    wait_idle();
                if ($urandom_range(0, 9) == 0)
                    k = KEY_W'($urandom_range(0, 16'hFFFF));
                else
                    k = key_pool[$urandom_range(0, pool_n - 1)];
                send_req(1'($urandom_range(0, 1)), k, $urandom);
            end
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
